// File: sv/mon_pkg.sv
package mon_pkg;

  // Default width of one window sample.
  localparam int unsigned SAMPLE_WIDTH = 16;

  // Samples in one 3x3 window.
  localparam int unsigned NUM_SAMPLES = 9;

endpackage

// File: sv/mon_if.sv
// Window channel: nine samples of a 3x3 window in row-major order.
interface mon_win_if #(
  parameter int unsigned SampleWidth = mon_pkg::SAMPLE_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [SampleWidth-1:0] sample_0;
  logic [SampleWidth-1:0] sample_1;
  logic [SampleWidth-1:0] sample_2;
  logic [SampleWidth-1:0] sample_3;
  logic [SampleWidth-1:0] sample_4;
  logic [SampleWidth-1:0] sample_5;
  logic [SampleWidth-1:0] sample_6;
  logic [SampleWidth-1:0] sample_7;
  logic [SampleWidth-1:0] sample_8;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8,
    input  ready
  );

  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8,
    output ready
  );
endinterface

// Median channel: one median word per window.
interface mon_med_if #(
  parameter int unsigned SampleWidth = mon_pkg::SAMPLE_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [SampleWidth-1:0] median_value;

  modport source (
    output valid, median_value,
    input  ready
  );

  modport sink (
    input  valid, median_value,
    output ready
  );
endinterface

// File: sv/median_of_nine.sv
// Channel    Dir  Width per field   Contents
// win_i      in   9 x SampleWidth   sample_0..sample_8, 3x3 window, row-major
// med_o      out  1 x SampleWidth   median_value, median of the window
//
// One window word is taken every cycle unless a stall on med_o backs up to win_i;
// its median passes the three register stages of the selection network:
// row sort, column/min/max, final median of three.
// Reset (rst_ni low, asynchronous) empties every stage; data registers are not reset.
// A stall on med_o holds the full stages in place and backs up to win_i.ready;
// empty stages keep filling, so nothing is lost or repeated.
module median_of_nine #(
  parameter int unsigned SampleWidth = mon_pkg::SAMPLE_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mon_win_if.sink   win_i,
  mon_med_if.source med_o
);

  localparam int unsigned NumSamples = mon_pkg::NUM_SAMPLES;

  typedef logic [SampleWidth-1:0] sample_t;
  typedef logic [2:0][SampleWidth-1:0] row_t;

  // Median of three values by compare only.
  function automatic sample_t med3(sample_t a, sample_t b, sample_t c);
    sample_t lo;
    sample_t hi;
    sample_t m;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    m  = (hi > c) ? c : hi;
    return (lo > m) ? lo : m;
  endfunction

  function automatic sample_t max3(sample_t a, sample_t b, sample_t c);
    sample_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic sample_t min3(sample_t a, sample_t b, sample_t c);
    sample_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  // Sorts a row of three with three compare-exchanges; element 0 is the smallest.
  function automatic row_t sort3(sample_t a, sample_t b, sample_t c);
    sample_t x;
    sample_t y;
    sample_t z;
    sample_t t;
    x = a;
    y = b;
    z = c;
    t = '0;
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    return {z, y, x};
  endfunction

  // Stage enables: a stage moves when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  logic win_acc;

  assign adv3        = !v3_q || med_o.ready;
  assign adv2        = !v2_q || adv3;
  assign adv1        = !v1_q || adv2;
  assign win_i.ready = adv1;
  assign win_acc     = win_i.valid && adv1;

  // Stage 1: sort each row of three with three compare-exchanges.
  sample_t win [NumSamples];
  sample_t s1_d [NumSamples];
  sample_t s1_q [NumSamples];

  assign win[0] = win_i.sample_0;
  assign win[1] = win_i.sample_1;
  assign win[2] = win_i.sample_2;
  assign win[3] = win_i.sample_3;
  assign win[4] = win_i.sample_4;
  assign win[5] = win_i.sample_5;
  assign win[6] = win_i.sample_6;
  assign win[7] = win_i.sample_7;
  assign win[8] = win_i.sample_8;

  assign {s1_d[2], s1_d[1], s1_d[0]} = sort3(win[0], win[1], win[2]);
  assign {s1_d[5], s1_d[4], s1_d[3]} = sort3(win[3], win[4], win[5]);
  assign {s1_d[8], s1_d[7], s1_d[6]} = sort3(win[6], win[7], win[8]);

  // Stage 2: largest row minimum, median of the middle column, smallest row maximum.
  sample_t lo_d, mid_d, hi_d;
  sample_t lo_q, mid_q, hi_q;

  assign lo_d  = max3(s1_q[0], s1_q[3], s1_q[6]);
  assign mid_d = med3(s1_q[1], s1_q[4], s1_q[7]);
  assign hi_d  = min3(s1_q[2], s1_q[5], s1_q[8]);

  // Stage 3: the centre of the sorted anti-diagonal is the median.
  sample_t med_d, med_q;

  assign med_d = med3(hi_q, mid_q, lo_q);

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= win_i.valid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Payload registers, loaded only when the stage moves.
  always_ff @(posedge clk_i) begin
    if (win_acc) begin
      s1_q <= s1_d;
    end
    if (adv2 && v1_q) begin
      lo_q  <= lo_d;
      mid_q <= mid_d;
      hi_q  <= hi_d;
    end
    if (adv3 && v2_q) begin
      med_q <= med_d;
    end
  end

  assign med_o.valid        = v3_q;
  assign med_o.median_value = med_q;

`ifndef NO_ASSERTIONS
  // Back-pressure reaches the input only when every stage is full and stalled.
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_i.ready |-> (v1_q && v2_q && v3_q && !med_o.ready))
    else $error("input stalled while the pipeline has room");

  // A full first stage holds its rows sorted.
  a_rows_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (s1_q[0] <= s1_q[1] && s1_q[1] <= s1_q[2] &&
              s1_q[3] <= s1_q[4] && s1_q[4] <= s1_q[5] &&
              s1_q[6] <= s1_q[7] && s1_q[7] <= s1_q[8]))
    else $error("row sort stage holds an unsorted row");

  // A stalled middle stage keeps its word.
  a_s2_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !adv2) |=> (v2_q && $stable(lo_q) && $stable(mid_q) && $stable(hi_q)))
    else $error("middle stage lost or changed a stalled word");

  // A stalled first stage keeps element 4 of its word.
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv1) |=> (v1_q && $stable(s1_q[4])))
    else $error("row sort stage lost or changed a stalled word");
`endif

endmodule
